@@ hdl/dq_pkg.sv @@
package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  localparam logic [DATA_W-1:0] NONE_VALUE = '1;

endpackage

@@ hdl/dq_ram.sv @@
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/double_ended_queue.sv @@
// Double-ended queue over a ring of DEPTH entries held in two mirrored RAMs.
// An accepted operation writes the RAMs at accept, the registered RAM read of the new
// front and back entries happens in S_READ, and the result is shown in S_OUT; busy stays
// high meanwhile, so no new operation is taken until the block is back in S_IDLE.
// The receiver cannot stall: out_valid is high for exactly one cycle per beat.
// Reset (rst_n low, synchronous) empties the queue and holds busy high; RAM is not cleared.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic signed [dq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [dq_pkg::DATA_W-1:0] out_back_value,
  output logic [dq_pkg::OCC_W-1:0]    out_occupancy,
  output logic                        out_is_empty
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [AW-1:0]   back_r, back_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  dq_status_t      status_r, status_nxt;

  logic            accept;
  logic            is_push;
  logic            empty_now;
  logic            full_now;
  logic [AW-1:0]   front_inc, front_dec, back_inc, back_dec;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [DATA_W-1:0] front_rd, back_rd;

  assign busy      = !rst_n || (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign is_push   = (in_operation == OP_PUSH_BACK) || (in_operation == OP_PUSH_FRONT);
  assign empty_now = (count_r == '0);
  assign full_now  = (count_r >= FULL_CNT);

  // Ring index steps; DEPTH need not be a power of two.
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign back_inc  = (back_r == LAST_IDX) ? '0 : back_r + AW'(1);
  assign back_dec  = (back_r == '0) ? LAST_IDX : back_r - AW'(1);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    state_nxt  = state_r;
    wr_en      = 1'b0;
    wr_addr    = front_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_READ;
          status_nxt = ST_DONE;
          if (is_push) begin
            if (full_now) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
              if (empty_now) begin
                back_nxt = front_r;
                wr_addr  = front_r;
              end else if (in_operation == OP_PUSH_BACK) begin
                back_nxt = back_inc;
                wr_addr  = back_inc;
              end else begin
                front_nxt = front_dec;
                wr_addr   = front_dec;
              end
            end
          end else begin
            if (empty_now) begin
              status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
              if (count_r == CW'(1)) begin
                back_nxt = front_r;
              end else if (in_operation == OP_POP_FRONT) begin
                front_nxt = front_inc;
              end else begin
                back_nxt = back_dec;
              end
            end
          end
        end
      end
      S_READ:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      front_r  <= '0;
      back_r   <= '0;
      count_r  <= '0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  // Two copies take every write so the front and back entries read in parallel.
  // Writes only happen at accept, so the read in S_READ never collides with one.
  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram_front (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (front_r),
    .rd_data (front_rd)
  );

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram_back (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (back_r),
    .rd_data (back_rd)
  );

  assign out_valid       = (state_r == S_OUT);
  assign out_status      = status_r;
  assign out_is_empty    = empty_now;
  assign out_occupancy   = OCC_W'(count_r);
  assign out_front_value = empty_now ? NONE_VALUE : front_rd;
  assign out_back_value  = empty_now ? NONE_VALUE : back_rd;

endmodule

@@ hdl/dq_checker.sv @@
module dq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [1:0]                  out_status,
  input logic signed [dq_pkg::DATA_W-1:0] out_front_value,
  input logic signed [dq_pkg::DATA_W-1:0] out_back_value,
  input logic [dq_pkg::OCC_W-1:0]    out_occupancy,
  input logic                        out_is_empty
);

  import dq_pkg::*;

  // Every beat taken on the input produces a result once the block has passed its read state.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result missing two cycles after an accepted beat");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching accepted beat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a beat");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_front_value == NONE_VALUE && out_back_value == NONE_VALUE &&
       out_occupancy == '0))
    else $error("empty queue reported with values or a nonzero count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_EMPTY ||
                   out_status == ST_FULL))
    else $error("result carries an unknown status");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

@@ tb/sv/double_ended_queue_tb.sv @@
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int AW = $clog2(DEPTH);
  localparam int RANDOM_OPS = 1400;
  localparam int DRAIN_POINT = 700;

  typedef struct packed {
    dq_status_t        status;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
  } dq_result_t;

  typedef struct packed {
    dq_op_t            op;
    logic [DATA_W-1:0] value;
    logic              typed;
    dq_result_t        want;
  } dir_row_t;

  // Rows with typed set carry their result written out; the others go to the predictor.
  localparam dir_row_t DIR_TABLE [25] = '{
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_EMPTY, NONE_VALUE, NONE_VALUE, 5'd0, 1'b1}},
    '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, NONE_VALUE, NONE_VALUE, 5'd0, 1'b1}},
    '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{ST_DONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0}},
    '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{ST_DONE, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0}},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_DONE, NONE_VALUE, NONE_VALUE, 5'd0, 1'b1}},
    '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, '{ST_DONE, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0}},
    '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h5555_5555, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'h8765_4321, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h3333_3333, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hCCCC_CCCC, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h00FF_00FF, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hFF00_FF00, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h7FFF_FFFE, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'h8000_0001, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h0123_4567, 1'b0, '0},
    '{OP_PUSH_BACK,  32'hDEAD_BEEF, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hFEED_FACE, 1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_operation;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_back_value;
  logic [OCC_W-1:0]         out_occupancy;
  logic                     out_is_empty;

  // Shadow copy of the deque used to predict each result.
  logic [DATA_W-1:0] ring [DEPTH];
  int                front_pos;
  int                back_pos;
  int                live_count;

  dq_result_t pending_results [$];
  int         fail_count;

  double_ended_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_front_value(out_front_value),
    .out_back_value (out_back_value),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  function automatic dq_result_t deque_apply(dq_op_t op, logic [DATA_W-1:0] val);
    dq_result_t r;
    r.status = ST_DONE;
    if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
      if (live_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (live_count == 0) begin
          back_pos = front_pos;
          ring[front_pos[AW-1:0]] = val;
        end else if (op == OP_PUSH_BACK) begin
          back_pos = (back_pos + 1) % DEPTH;
          ring[back_pos[AW-1:0]] = val;
        end else begin
          front_pos = (front_pos + DEPTH - 1) % DEPTH;
          ring[front_pos[AW-1:0]] = val;
        end
        live_count++;
      end
    end else if (live_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      live_count--;
      if (live_count == 0) begin
        back_pos = front_pos;
      end else if (op == OP_POP_FRONT) begin
        front_pos = (front_pos + 1) % DEPTH;
      end else begin
        back_pos = (back_pos + DEPTH - 1) % DEPTH;
      end
    end
    if (live_count == 0) begin
      r.front_value = NONE_VALUE;
      r.back_value  = NONE_VALUE;
      r.is_empty    = 1'b1;
    end else begin
      r.front_value = ring[front_pos[AW-1:0]];
      r.back_value  = ring[back_pos[AW-1:0]];
      r.is_empty    = 1'b0;
    end
    r.occupancy = live_count[OCC_W-1:0];
    return r;
  endfunction

  // Holds the operation on the inputs until a beat is taken, then records its result.
  task automatic send_op(input dq_op_t op, input logic [DATA_W-1:0] val,
                         input logic typed, input dq_result_t want);
    dq_result_t got;
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = deque_apply(op, val);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    dq_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no operation outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(out_status));
        check_field("front_value", want.front_value, out_front_value);
        check_field("back_value", want.back_value, out_back_value);
        check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(out_occupancy));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_is_empty));
      end
    end
  end

  initial begin
    int         sent;
    int         burst_len;
    int         mode;
    int         gap;
    int         roll;
    bit         drained;
    dq_op_t     op;
    logic [DATA_W-1:0] val;

    fail_count = 0;
    front_pos  = 0;
    back_pos   = 0;
    live_count = 0;
    sent       = 0;
    drained    = 1'b0;

    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= OP_PUSH_BACK;
    in_value     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TABLE[i]) begin
      send_op(DIR_TABLE[i].op, DIR_TABLE[i].value, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end
    start <= 1'b0;
    wait_drained();

    // Bursts lean toward filling, draining or mixing so both full and empty recur.
    while (sent < RANDOM_OPS) begin
      burst_len = $urandom_range(1, 24);
      mode = $urandom_range(0, 2);
      for (int b = 0; b < burst_len; b++) begin
        roll = $urandom_range(0, 99);
        if ((mode == 0 && roll < 75) || (mode == 1 && roll < 25) || (mode == 2 && roll < 50))
          op = ($urandom_range(0, 1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
          op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
        case ($urandom_range(0, 7))
          0: val = 32'h7FFF_FFFF;
          1: val = 32'h8000_0000;
          2: val = '1;
          3: val = '0;
          default: val = $urandom;
        endcase
        send_op(op, val, 1'b0, '0);
        sent++;
      end
      if (!drained && sent >= DRAIN_POINT) begin
        start <= 1'b0;
        wait_drained();
        drained = 1'b1;
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
